/* src/mlf_pkg.sv */
package mlf_pkg;

    // Widths and defaults
    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 32;
    localparam int OUT_LEN_W           = 17;
    localparam int MAX_LEN_W           = 16;
    localparam int PREFIX_W            = 8;
    localparam int COUNT_W             = 32;

    // Stream characters
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_NL    = 8'd10;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LINE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WARN_START      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LENGTH   = 2'd2;

    // Register reset values
    localparam logic [MAX_LEN_W-1:0] MAX_LINE_LENGTH_RESET = 16'd1024;
    localparam logic [COUNT_W-1:0]   WARN_START_RESET      = 32'd1;
    localparam logic [PREFIX_W-1:0]  PREFIX_LENGTH_RESET   = 8'd0;

    // Descriptor status codes
    typedef enum logic [1:0] {
        STATUS_ACCEPTED   = 2'd0,
        STATUS_OVERLENGTH = 2'd1,
        STATUS_NO_SEP     = 2'd2
    } status_t;

    // Summary of the line held in the scanner, valid when a newline arrives
    typedef struct packed {
        logic                 nonempty;
        logic                 overlength;
        logic                 sep_found;
        logic                 sep_kind;
        logic [OUT_LEN_W-1:0] line_length;
        logic [OUT_LEN_W-1:0] key_length;
    } line_summary_t;

    // Overlength bookkeeping for the line ending on this beat
    typedef struct packed {
        logic               warn;
        logic [COUNT_W-1:0] total;
    } ovl_result_t;

endpackage

/* src/mlf_line_scan.sv */
module mlf_line_scan #(
    parameter int LENGTH_BITS = mlf_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_beat,
    input  logic [7:0]                     data_byte,
    input  logic [mlf_pkg::MAX_LEN_W-1:0]  max_line_length,
    input  logic [mlf_pkg::PREFIX_W-1:0]   prefix_length,
    output mlf_pkg::line_summary_t         summary
);

    localparam logic [LENGTH_BITS-1:0] RAW_SAT = '1;
    localparam int CMP_W  = (LENGTH_BITS > mlf_pkg::MAX_LEN_W) ? LENGTH_BITS
                                                                : mlf_pkg::MAX_LEN_W;
    localparam int WIDE_W = (LENGTH_BITS + 1 > mlf_pkg::OUT_LEN_W) ? LENGTH_BITS + 1
                                                                     : mlf_pkg::OUT_LEN_W;

    logic [LENGTH_BITS-1:0] raw_count_reg, raw_count_next;
    logic                   lead_cr_reg, lead_cr_next;
    logic                   last_cr_reg, last_cr_next;
    logic [LENGTH_BITS-1:0] space_pos_reg, space_pos_next;
    logic                   space_seen_reg, space_seen_next;
    logic [LENGTH_BITS-1:0] colon_pos_reg, colon_pos_next;
    logic                   colon_seen_reg, colon_seen_next;

    logic [LENGTH_BITS-1:0] len_lead;
    logic [LENGTH_BITS-1:0] len_strip;
    logic [LENGTH_BITS-1:0] sep_pos;
    logic [WIDE_W-1:0]      line_sum;
    logic [WIDE_W-1:0]      key_sum;

    // Advance the per-line state on each beat; clear it at newline
    always_comb
    begin
        raw_count_next  = raw_count_reg;
        lead_cr_next    = lead_cr_reg;
        last_cr_next    = last_cr_reg;
        space_pos_next  = space_pos_reg;
        space_seen_next = space_seen_reg;
        colon_pos_next  = colon_pos_reg;
        colon_seen_next = colon_seen_reg;
        if (byte_beat)
        begin
            if (data_byte == mlf_pkg::CH_NL)
            begin
                raw_count_next  = '0;
                lead_cr_next    = 1'b0;
                last_cr_next    = 1'b0;
                space_pos_next  = '0;
                space_seen_next = 1'b0;
                colon_pos_next  = '0;
                colon_seen_next = 1'b0;
            end
            else
            begin
                // Bytes past saturation are neither counted nor searched
                if (raw_count_reg != RAW_SAT)
                begin
                    if (raw_count_reg == '0 && data_byte == mlf_pkg::CH_CR)
                    begin
                        lead_cr_next = 1'b1;
                    end
                    if (data_byte == mlf_pkg::CH_SPACE && !space_seen_reg)
                    begin
                        space_pos_next  = raw_count_reg;
                        space_seen_next = 1'b1;
                    end
                    if (data_byte == mlf_pkg::CH_COLON && !colon_seen_reg)
                    begin
                        colon_pos_next  = raw_count_reg;
                        colon_seen_next = 1'b1;
                    end
                    raw_count_next = raw_count_reg + 1'b1;
                end
                last_cr_next = (data_byte == mlf_pkg::CH_CR);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_count_reg  <= '0;
            lead_cr_reg    <= 1'b0;
            last_cr_reg    <= 1'b0;
            space_pos_reg  <= '0;
            space_seen_reg <= 1'b0;
            colon_pos_reg  <= '0;
            colon_seen_reg <= 1'b0;
        end
        else
        begin
            raw_count_reg  <= raw_count_next;
            lead_cr_reg    <= lead_cr_next;
            last_cr_reg    <= last_cr_next;
            space_pos_reg  <= space_pos_next;
            space_seen_reg <= space_seen_next;
            colon_pos_reg  <= colon_pos_next;
            colon_seen_reg <= colon_seen_next;
        end
    end

    // Strip one leading and one trailing carriage return
    always_comb
    begin
        len_lead  = raw_count_reg - LENGTH_BITS'(lead_cr_reg);
        len_strip = (len_lead != '0 && last_cr_reg) ? len_lead - 1'b1 : len_lead;
        sep_pos   = space_seen_reg ? space_pos_reg : colon_pos_reg;
        line_sum  = WIDE_W'(len_strip) + WIDE_W'(prefix_length);
        key_sum   = WIDE_W'(sep_pos) - WIDE_W'(lead_cr_reg) + WIDE_W'(prefix_length);
    end

    // Describe the held line
    always_comb
    begin
        summary.nonempty    = (len_strip != '0);
        summary.overlength  = (raw_count_reg == RAW_SAT) ||
                              (CMP_W'(len_strip) > CMP_W'(max_line_length));
        summary.sep_found   = space_seen_reg || colon_seen_reg;
        summary.sep_kind    = !space_seen_reg;
        summary.line_length = line_sum[mlf_pkg::OUT_LEN_W-1:0];
        summary.key_length  = key_sum[mlf_pkg::OUT_LEN_W-1:0];
    end

endmodule

/* src/mlf_overlength.sv */
module mlf_overlength (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           line_hit,
    input  logic                           cfg_load,
    input  logic [mlf_pkg::COUNT_W-1:0]    cfg_value,
    output mlf_pkg::ovl_result_t           result
);

    localparam int CW = mlf_pkg::COUNT_W;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] thr_reg, thr_next;
    logic          grow_pending_reg, grow_pending_next;
    logic          warn;
    logic [CW-1:0] grown;

    // Count the overlength line, saturating, and test the threshold
    always_comb
    begin
        count_next = count_reg;
        if (line_hit && count_reg != '1)
        begin
            count_next = count_reg + 1'b1;
        end
        warn              = line_hit && (count_next >= thr_reg);
        grow_pending_next = warn;
    end

    // Smallest doubling of the threshold above the count, else all ones
    always_comb
    begin
        logic [CW-1:0]   base;
        logic [2*CW-1:0] shifted;
        base    = (thr_reg == '0) ? CW'(1) : thr_reg;
        grown   = '1;
        shifted = '0;
        for (int k = CW - 1; k >= 0; k--)
        begin
            shifted = {{CW{1'b0}}, base} << k;
            if (shifted[2*CW-1:CW] == '0 && shifted[CW-1:0] > count_reg)
            begin
                grown = shifted[CW-1:0];
            end
        end
    end

    // Grow in the cycle after a warning; a register write takes precedence
    always_comb
    begin
        thr_next = thr_reg;
        if (cfg_load)
        begin
            thr_next = cfg_value;
        end
        else if (grow_pending_reg)
        begin
            thr_next = grown;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            thr_reg          <= mlf_pkg::WARN_START_RESET;
            grow_pending_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            thr_reg          <= thr_next;
            grow_pending_reg <= grow_pending_next;
        end
    end

    assign result.warn  = warn;
    assign result.total = count_next;

endmodule

/* src/metric_line_framer.sv */
// A descriptor is presented in the cycle after the newline beat that ends its line.
// Throughput: one byte per cycle; a newline waits only while a descriptor is held
// in the result register and out_ready is low.
// Threshold growth after a warning is registered in grow_pending_reg, then loaded into thr_reg.
// Reset (rst_n, asynchronous, active low) clears line state, counters and the result
// valid flag, and loads every configuration register with its default.
module metric_line_framer #(
    parameter int LENGTH_BITS = mlf_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [mlf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mlf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [mlf_pkg::OUT_LEN_W-1:0]     line_length,
    output logic [mlf_pkg::OUT_LEN_W-1:0]     key_length,
    output logic                              separator_kind,
    output logic                              overlength_warning,
    output logic [mlf_pkg::COUNT_W-1:0]       overlength_total
);

    logic [mlf_pkg::MAX_LEN_W-1:0] max_len_reg, max_len_next;
    logic [mlf_pkg::PREFIX_W-1:0]  prefix_reg, prefix_next;
    logic                          warn_start_load;

    mlf_pkg::line_summary_t summary;
    mlf_pkg::ovl_result_t   ovl;

    logic in_beat;
    logic line_end;
    logic line_hit;

    logic                          out_valid_reg, out_valid_next;
    mlf_pkg::status_t              status_reg, status_next;
    logic [mlf_pkg::OUT_LEN_W-1:0] line_len_reg, line_len_next;
    logic [mlf_pkg::OUT_LEN_W-1:0] key_len_reg, key_len_next;
    logic                          kind_reg, kind_next;
    logic                          warn_reg, warn_next;
    logic [mlf_pkg::COUNT_W-1:0]   total_reg, total_next;

    // Configuration writes
    always_comb
    begin
        max_len_next    = max_len_reg;
        prefix_next     = prefix_reg;
        warn_start_load = 1'b0;
        if (cfg_write_enable)
        begin
            case (cfg_index)
                mlf_pkg::REG_MAX_LINE_LENGTH: max_len_next = cfg_data[mlf_pkg::MAX_LEN_W-1:0];
                mlf_pkg::REG_WARN_START:      warn_start_load = 1'b1;
                mlf_pkg::REG_PREFIX_LENGTH:   prefix_next = cfg_data[mlf_pkg::PREFIX_W-1:0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= mlf_pkg::MAX_LINE_LENGTH_RESET;
            prefix_reg  <= mlf_pkg::PREFIX_LENGTH_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
            prefix_reg  <= prefix_next;
        end
    end

    // Take any byte other than a newline; hold a newline while the result is stuck
    assign in_ready = !out_valid_reg || out_ready || (data_byte != mlf_pkg::CH_NL);
    assign in_beat  = in_valid && in_ready;
    assign line_end = in_beat && (data_byte == mlf_pkg::CH_NL) && summary.nonempty;
    assign line_hit = line_end && summary.overlength;

    mlf_line_scan #(
        .LENGTH_BITS     (LENGTH_BITS)
    ) u_scan (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_beat       (in_beat),
        .data_byte       (data_byte),
        .max_line_length (max_len_reg),
        .prefix_length   (prefix_reg),
        .summary         (summary)
    );

    mlf_overlength u_ovl (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_hit  (line_hit),
        .cfg_load  (warn_start_load),
        .cfg_value (cfg_data[mlf_pkg::COUNT_W-1:0]),
        .result    (ovl)
    );

    // Build the descriptor for a line ending on this beat
    always_comb
    begin
        status_next   = status_reg;
        line_len_next = line_len_reg;
        key_len_next  = key_len_reg;
        kind_next     = kind_reg;
        warn_next     = warn_reg;
        total_next    = total_reg;
        if (line_end)
        begin
            line_len_next = '0;
            key_len_next  = '0;
            kind_next     = 1'b0;
            warn_next     = 1'b0;
            total_next    = ovl.total;
            if (summary.overlength)
            begin
                status_next = mlf_pkg::STATUS_OVERLENGTH;
                warn_next   = ovl.warn;
            end
            else if (summary.sep_found)
            begin
                status_next   = mlf_pkg::STATUS_ACCEPTED;
                line_len_next = summary.line_length;
                key_len_next  = summary.key_length;
                kind_next     = summary.sep_kind;
            end
            else
            begin
                status_next = mlf_pkg::STATUS_NO_SEP;
            end
        end
    end

    // Result register valid: load on a line end, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (line_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        line_len_reg <= line_len_next;
        key_len_reg  <= key_len_next;
        kind_reg     <= kind_next;
        warn_reg     <= warn_next;
        total_reg    <= total_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign line_length        = line_len_reg;
    assign key_length         = key_len_reg;
    assign separator_kind     = kind_reg;
    assign overlength_warning = warn_reg;
    assign overlength_total   = total_reg;

endmodule

/* tb/sv/tb_metric_line_framer.sv */
module tb_metric_line_framer;

    localparam int STUCK_LIMIT = 5000;
    localparam int PHASE_BEATS = 180;
    localparam int OUT_W       = mlf_pkg::OUT_LEN_W;
    localparam int CNT_W       = mlf_pkg::COUNT_W;
    localparam int IDX_W       = mlf_pkg::CFG_INDEX_W;
    localparam int DAT_W       = mlf_pkg::CFG_DATA_W;

    // One line descriptor as the block reports it
    typedef struct packed {
        mlf_pkg::status_t status;
        logic [OUT_W-1:0] line_len;
        logic [OUT_W-1:0] key_len;
        logic             kind;
        logic             warn;
        logic [CNT_W-1:0] total;
    } line_desc_t;

    typedef enum logic {
        ROW_LINE,
        ROW_WRITE
    } row_kind_t;

    // Directed row: head text, a run of one fill byte, tail text, or a register write
    typedef struct {
        row_kind_t        kind;
        string            head;
        logic [7:0]       fill;
        int               fill_n;
        string            tail;
        bit               typed;
        line_desc_t       want;
        logic [IDX_W-1:0] reg_index;
        logic [DAT_W-1:0] reg_value;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_enable;
    logic [IDX_W-1:0] cfg_index;
    logic [DAT_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       data_byte;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [OUT_W-1:0] line_length;
    logic [OUT_W-1:0] key_length;
    logic             separator_kind;
    logic             overlength_warning;
    logic [CNT_W-1:0] overlength_total;

    // Framer state mirrored by the predictor
    logic [15:0]  raw_cnt;
    logic [15:0]  space_at;
    logic [15:0]  colon_at;
    bit           lead_cr;
    bit           last_cr;
    bit           space_seen;
    bit           colon_seen;
    logic [31:0]  ovl_cnt;
    logic [31:0]  warn_thr;
    logic [15:0]  max_len;
    logic [7:0]   pfx_len;

    line_desc_t   descs_due[$];
    row_t         stim_rows[$];
    bit           use_typed;
    line_desc_t   typed_want;
    bit           send_idle;
    bit           recv_idle;
    bit           hold_req;
    int           beats_in;
    int           mismatches;

    metric_line_framer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .data_byte          (data_byte),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .line_length        (line_length),
        .key_length         (key_length),
        .separator_kind     (separator_kind),
        .overlength_warning (overlength_warning),
        .overlength_total   (overlength_total)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void clear_line_state();
        raw_cnt    = '0;
        space_at   = '0;
        colon_at   = '0;
        lead_cr    = 1'b0;
        last_cr    = 1'b0;
        space_seen = 1'b0;
        colon_seen = 1'b0;
    endfunction

    // Advance the framer by one byte; return 1 when a descriptor is due
    function automatic bit frame_byte(input logic [7:0] b, output line_desc_t d);
        int unsigned len;
        int unsigned pos;
        int          k;
        d = '0;
        if (b != mlf_pkg::CH_NL)
        begin
            if (raw_cnt != 16'hFFFF)
            begin
                if (raw_cnt == 16'd0 && b == mlf_pkg::CH_CR)
                    lead_cr = 1'b1;
                if (b == mlf_pkg::CH_SPACE && !space_seen)
                begin
                    space_at   = raw_cnt;
                    space_seen = 1'b1;
                end
                if (b == mlf_pkg::CH_COLON && !colon_seen)
                begin
                    colon_at   = raw_cnt;
                    colon_seen = 1'b1;
                end
                raw_cnt = raw_cnt + 16'd1;
            end
            last_cr = (b == mlf_pkg::CH_CR);
            return 1'b0;
        end
        len = 32'(raw_cnt) - (lead_cr ? 32'd1 : 32'd0);
        if (len > 0 && last_cr)
            len--;
        if (len == 0)
        begin
            clear_line_state();
            return 1'b0;
        end
        if (raw_cnt == 16'hFFFF || len > 32'(max_len))
        begin
            d.status = mlf_pkg::STATUS_OVERLENGTH;
            if (ovl_cnt != 32'hFFFF_FFFF)
                ovl_cnt = ovl_cnt + 32'd1;
            if (ovl_cnt >= warn_thr)
            begin
                d.warn = 1'b1;
                // double the threshold until it passes the count, saturating at the top
                for (k = 0; k < 34 && ovl_cnt >= warn_thr; k++)
                begin
                    if (warn_thr == 32'd0)
                    begin
                        warn_thr = 32'd1;
                    end
                    else if (warn_thr >= 32'h8000_0000)
                    begin
                        warn_thr = 32'hFFFF_FFFF;
                        break;
                    end
                    else
                    begin
                        warn_thr = warn_thr << 1;
                    end
                end
            end
        end
        else if (space_seen || colon_seen)
        begin
            pos        = 32'(space_seen ? space_at : colon_at);
            d.status   = mlf_pkg::STATUS_ACCEPTED;
            d.kind     = !space_seen;
            d.key_len  = OUT_W'(pos - (lead_cr ? 32'd1 : 32'd0) + 32'(pfx_len));
            d.line_len = OUT_W'(len + 32'(pfx_len));
        end
        else
        begin
            d.status = mlf_pkg::STATUS_NO_SEP;
        end
        d.total = ovl_cnt;
        clear_line_state();
        return 1'b1;
    endfunction

    function automatic void add_line(string head, logic [7:0] fill, int fill_n, string tail,
                                     bit typed = 1'b0, line_desc_t want = '0);
        row_t r;
        r.kind      = ROW_LINE;
        r.head      = head;
        r.fill      = fill;
        r.fill_n    = fill_n;
        r.tail      = tail;
        r.typed     = typed;
        r.want      = want;
        r.reg_index = '0;
        r.reg_value = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_write(logic [IDX_W-1:0] idx, logic [DAT_W-1:0] val);
        row_t r;
        r.kind      = ROW_WRITE;
        r.head      = "";
        r.fill      = '0;
        r.fill_n    = 0;
        r.tail      = "";
        r.typed     = 1'b0;
        r.want      = '0;
        r.reg_index = idx;
        r.reg_value = val;
        stim_rows.push_back(r);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Offer one byte, hold it until the beat is taken, then predict
    task automatic send_byte(input logic [7:0] b);
        line_desc_t d;
        int         gap;
        if (send_idle && $urandom_range(0, 15) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        beats_in++;
        if (frame_byte(b, d))
        begin
            if (use_typed)
                d = typed_want;
            descs_due.push_back(d);
        end
    endtask

    // Drop valid and let the block go quiet before a register write
    task automatic drain();
        in_valid <= 1'b0;
        while (descs_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        case (idx)
            mlf_pkg::REG_MAX_LINE_LENGTH: max_len = val[15:0];
            mlf_pkg::REG_WARN_START:      warn_thr = val;
            mlf_pkg::REG_PREFIX_LENGTH:   pfx_len = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Mostly well-formed lines with separators and carriage returns, some noise
    task automatic send_random_line();
        int         n;
        int         lim;
        int         k;
        logic [7:0] b;
        lim = (max_len <= 60) ? int'(max_len) + 3 : 40;
        if ($urandom_range(0, 3) == 0)
            send_byte(mlf_pkg::CH_CR);
        n = $urandom_range(0, lim);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 15))
                0:       b = mlf_pkg::CH_SPACE;
                1:       b = mlf_pkg::CH_COLON;
                2:       b = mlf_pkg::CH_CR;
                3:       b = 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(33, 126));
            endcase
            send_byte(b);
        end
        if ($urandom_range(0, 3) == 0)
            send_byte(mlf_pkg::CH_CR);
        if ($urandom_range(0, 15) != 0)
            send_byte(mlf_pkg::CH_NL);
    endtask

    // Receiver: check each descriptor beat, stall in bursts, hold off long on request
    initial
    begin
        int         hold;
        line_desc_t want;
        hold      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (descs_due.size() == 0)
                begin
                    mismatches++;
                    $error("descriptor: expected none, actual status %0d", status);
                end
                else
                begin
                    want = descs_due.pop_front();
                    check_field("status", want.status, status);
                    check_field("line_length", want.line_len, line_length);
                    check_field("key_length", want.key_len, key_length);
                    check_field("separator_kind", want.kind, separator_kind);
                    check_field("overlength_warning", want.warn, overlength_warning);
                    check_field("overlength_total", want.total, overlength_total);
                end
            end
            if (hold == 0 && hold_req)
            begin
                hold     = 400;
                hold_req = 1'b0;
            end
            else if (hold == 0 && recv_idle && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 19);
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    initial
    begin
        int stuck;
        stuck = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int           j;
        int           ph;
        int           start;
        row_t         r;
        logic [31:0]  mx;
        logic [31:0]  ws;
        logic [31:0]  px;

        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        data_byte        = '0;
        use_typed        = 1'b0;
        typed_want       = '0;
        send_idle        = 1'b1;
        recv_idle        = 1'b1;
        hold_req         = 1'b0;
        beats_in         = 0;
        mismatches       = 0;
        clear_line_state();
        ovl_cnt  = '0;
        max_len  = mlf_pkg::MAX_LINE_LENGTH_RESET;
        pfx_len  = mlf_pkg::PREFIX_LENGTH_RESET;
        warn_thr = mlf_pkg::WARN_START_RESET;

        // Directed lines, first under the reset settings
        add_line("a b\n", 8'h00, 0, "", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_ACCEPTED, 17'd3, 17'd1, 1'b0, 1'b0, 32'd0});
        add_line("k:v\n", 8'h00, 0, "", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_ACCEPTED, 17'd3, 17'd1, 1'b1, 1'b0, 32'd0});
        add_line("\n", 8'h00, 0, "");
        add_line("\015\n", 8'h00, 0, "");
        add_line("\015\015\n", 8'h00, 0, "");
        add_line("abc\n", 8'h00, 0, "", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_NO_SEP, 17'd0, 17'd0, 1'b0, 1'b0, 32'd0});
        add_line("\015x y\015\n", 8'h00, 0, "");
        add_line("a:b c\n", 8'h00, 0, "");
        add_line(" \n", 8'h00, 0, "");
        add_line("\015:\n", 8'h00, 0, "");
        add_line("x\015\015y\n", 8'h00, 0, "");
        add_line("q:", 8'h00, 0, "");
        add_line("r s\n", 8'h00, 0, "");
        add_line("", 8'h00, 3, "\377 \n");
        // Short limit: overlength lines, warnings and threshold growth
        add_write(mlf_pkg::REG_MAX_LINE_LENGTH, 32'd8);
        add_line("", "a", 9, "\n", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_OVERLENGTH, 17'd0, 17'd0, 1'b0, 1'b1, 32'd1});
        add_line("", "a", 10, " \n", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_OVERLENGTH, 17'd0, 17'd0, 1'b0, 1'b1, 32'd2});
        add_line("", "b", 12, "\n", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_OVERLENGTH, 17'd0, 17'd0, 1'b0, 1'b0, 32'd3});
        add_line("", "a", 6, " b\n");
        add_line("\015", "c", 8, ":\015\n");
        // Limit of 65534 and largest prefix
        add_write(mlf_pkg::REG_MAX_LINE_LENGTH, 32'd65534);
        add_write(mlf_pkg::REG_PREFIX_LENGTH, 32'd255);
        add_line("a b\n", 8'h00, 0, "", 1'b1,
                 line_desc_t'{mlf_pkg::STATUS_ACCEPTED, 17'd258, 17'd256, 1'b0, 1'b0, 32'd4});
        add_line("", "a", 40, " :\n");
        // Zero limit, then zero threshold
        add_write(mlf_pkg::REG_MAX_LINE_LENGTH, 32'd0);
        add_line("z\n", 8'h00, 0, "");
        add_write(mlf_pkg::REG_WARN_START, 32'd0);
        add_line("z z\n", 8'h00, 0, "");

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (stim_rows[i])
        begin
            r = stim_rows[i];
            if (r.kind == ROW_WRITE)
            begin
                drain();
                write_reg(r.reg_index, r.reg_value);
            end
            else
            begin
                use_typed  = r.typed;
                typed_want = r.want;
                send_idle  = (r.fill_n < 2000);
                for (j = 0; j < r.head.len(); j++)
                    send_byte(r.head[j]);
                for (j = 0; j < r.fill_n; j++)
                    send_byte(r.fill);
                for (j = 0; j < r.tail.len(); j++)
                    send_byte(r.tail[j]);
            end
        end
        use_typed = 1'b0;

        // Random lines across several register settings
        for (ph = 0; ph < 10; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    mx = 32'd1;
                    ws = 32'd1;
                    px = 32'd0;
                end
                1:
                begin
                    mx = 32'd65534;
                    ws = 32'hFFFF_FFFF;
                    px = 32'd255;
                end
                2:
                begin
                    mx = 32'd8;
                    ws = 32'd0;
                    px = 32'd255;
                end
                3:
                begin
                    mx = $urandom_range(2, 40);
                    ws = $urandom_range(1, 6);
                    px = $urandom_range(0, 255);
                end
                default:
                begin
                    mx = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65534)
                                                     : $urandom_range(1, 48);
                    ws = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 12);
                    px = $urandom_range(0, 255);
                end
            endcase
            write_reg(mlf_pkg::REG_MAX_LINE_LENGTH, mx);
            write_reg(mlf_pkg::REG_WARN_START, ws);
            write_reg(mlf_pkg::REG_PREFIX_LENGTH, px);
            // phase 3 fills the block against a long receiver hold; the last phase runs flat out
            send_idle = (ph != 3 && ph != 9 && $urandom_range(0, 3) != 0);
            recv_idle = (ph != 9 && $urandom_range(0, 3) != 0);
            if (ph == 3)
                hold_req = 1'b1;
            start = beats_in;
            while (beats_in - start < PHASE_BEATS)
                send_random_line();
            send_byte(mlf_pkg::CH_NL);
        end

        // Wait out the last descriptors
        in_valid <= 1'b0;
        while (descs_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
src/mlf_pkg.sv
src/mlf_line_scan.sv
src/mlf_overlength.sv
src/metric_line_framer.sv
tb/sv/tb_metric_line_framer.sv
